// ----- src/isc_pkg.sv -----
// Shared constants, types and codes for the image scaler.
package isc_pkg;

  // Frame store geometry and pixel format.
  localparam int MAX_DIM      = 64;
  localparam int CHANNEL_BITS = 8;
  localparam int NUM_CH       = 3;
  localparam int DIM_W        = $clog2(MAX_DIM);
  localparam int ADDR_W       = 2 * DIM_W;
  localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;

  // Field and register widths.
  localparam int COORD_W    = 9;
  localparam int SCALE_W    = 10;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Scale constants.
  localparam int PERCENT_UNITY = 100;
  localparam int PERCENT_HALF  = 50;

  // Range check works on products of a size and a percent.
  localparam int RANGE_W = SIZE_W + SCALE_W;

  // Divider: quotient is a source coordinate, so it is below MAX_DIM.
  localparam int QUO_W      = DIM_W;
  localparam int DIVIDEND_W = 16;
  localparam int CNT_W      = $clog2(QUO_W + 1);
  localparam int DSR_W      = SCALE_W + QUO_W - 1;
  localparam int CMP_W      = (DIVIDEND_W > DSR_W) ? DIVIDEND_W : DSR_W;

  // Box filter.
  localparam int ACC_W      = CHANNEL_BITS + 2;
  localparam int BOX_READS  = 4;
  localparam int BOX_CNT_W  = 3;

  // Channel 2 is red, 1 is green, 0 is blue.
  typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] pixel_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_RANGE       = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 2'd0,
    REG_ROWS  = 2'd1,
    REG_COLS  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVR,
    S_DIVC,
    S_NNDAT,
    S_BOX,
    S_AVG,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- src/isc_frame_store.sv -----
// Source image memory: one write port, one registered read port.
module isc_frame_store import isc_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  pixel_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output pixel_t            rd_data
);

  pixel_t mem [STORE_DEPTH];
  pixel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/isc_divider.sv -----
// Restoring divider producing one quotient bit per cycle.
module isc_divider import isc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [SCALE_W-1:0]    divisor,
  output logic [QUO_W-1:0]      quotient,
  output div_stat_t             stat
);

  logic [DIVIDEND_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0]      dsr_r, dsr_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  ge;

  // The caller guarantees the quotient is below 2**QUO_W, so the shifted
  // divisor starts at QUO_W-1 places.
  always_comb begin
    ge       = CMP_W'(rem_r) >= CMP_W'(dsr_r);
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      dsr_nxt  = DSR_W'(divisor) << (QUO_W - 1);
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - DIVIDEND_W'(dsr_r);
      end
      quo_nxt = QUO_W'({quo_r, ge});
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- src/image_scaler_nearest_and_box.sv -----
// Top level of the image scaler: frame store, shared divider and sequencer.
// A write request is stored at its accepting edge, gives no result and frees the
// input at once. A read's result comes soonest for an unsupported percent or an
// out-of-range coordinate, later for a half-scale box read and last for a nearest
// read, whose two six-step passes through the shared divider run one after the other.
// Reads do not overlap; a waiting result that holds the output delays the next one.
// Synchronous active-low reset restores 100 %, 64x64 and clears the output valid.
module image_scaler_nearest_and_box import isc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_operation,
  input  logic [COORD_W-1:0]      in_row,
  input  logic [COORD_W-1:0]      in_col,
  input  logic [CHANNEL_BITS-1:0] in_red_in,
  input  logic [CHANNEL_BITS-1:0] in_green_in,
  input  logic [CHANNEL_BITS-1:0] in_blue_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHANNEL_BITS-1:0] out_red_out,
  output logic [CHANNEL_BITS-1:0] out_green_out,
  output logic [CHANNEL_BITS-1:0] out_blue_out,
  output logic [1:0]              out_status
);

  // Configuration registers. The user must write them only while the block is idle;
  // the block itself does not enforce this. The port is always ready.
  logic [SCALE_W-1:0] scale_r;
  logic [SIZE_W-1:0]  rows_r;
  logic [SIZE_W-1:0]  cols_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_W'(PERCENT_UNITY);
      rows_r  <= SIZE_W'(MAX_DIM);
      cols_r  <= SIZE_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE: scale_r <= cfg_data;
        REG_ROWS:  rows_r  <= SIZE_W'(cfg_data);
        REG_COLS:  cols_r  <= SIZE_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Sizes above the store dimension behave as the store dimension.
  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;

  assign rows_eff = (int'(rows_r) > MAX_DIM) ? SIZE_W'(MAX_DIM) : rows_r;
  assign cols_eff = (int'(cols_r) > MAX_DIM) ? SIZE_W'(MAX_DIM) : cols_r;

  // Request acceptance. Only the idle state takes a new request.
  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // A write request goes straight into the frame store, provided it lies
  // inside the configured source image; otherwise it is dropped.
  logic   wr_en;
  pixel_t wr_pix;

  assign wr_en = in_fire && (in_operation == OP_WRITE) &&
                 ((COORD_W)'(rows_eff) > in_row) && ((COORD_W)'(cols_eff) > in_col);
  assign wr_pix = {in_red_in, in_green_in, in_blue_in};

  // The output coordinate of a read request is held for the whole sequence.
  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_r <= in_row;
      col_r <= in_col;
    end
  end

  // Checks on the percent and the coordinate. The output size is
  // floor(size * percent / 100); a coordinate is inside it exactly when
  // (coord + 1) * 100 <= size * percent, which needs no division.
  logic               pct_half;
  logic               pct_unsupported;
  logic [RANGE_W-1:0] row_need;
  logic [RANGE_W-1:0] col_need;
  logic [RANGE_W-1:0] row_have;
  logic [RANGE_W-1:0] col_have;
  logic               coord_ok;

  assign pct_half        = (scale_r == SCALE_W'(PERCENT_HALF));
  assign pct_unsupported = !pct_half && (scale_r < SCALE_W'(PERCENT_UNITY));
  assign row_need = (RANGE_W'(row_r) + 1'b1) * RANGE_W'(PERCENT_UNITY);
  assign col_need = (RANGE_W'(col_r) + 1'b1) * RANGE_W'(PERCENT_UNITY);
  assign row_have = RANGE_W'(rows_eff) * RANGE_W'(scale_r);
  assign col_have = RANGE_W'(cols_eff) * RANGE_W'(scale_r);
  assign coord_ok = (row_need <= row_have) && (col_need <= col_have);

  // Shared divider. It is run twice per nearest-neighbour read: once for
  // row * 100 / percent and once for col * 100 / percent.
  logic [DIVIDEND_W-1:0] row_x100;
  logic [DIVIDEND_W-1:0] col_x100;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic                  div_start;
  logic [QUO_W-1:0]      div_quo;
  div_stat_t             div_stat;

  assign row_x100 = DIVIDEND_W'(row_r) * DIVIDEND_W'(PERCENT_UNITY);
  assign col_x100 = DIVIDEND_W'(col_r) * DIVIDEND_W'(PERCENT_UNITY);

  isc_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (scale_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Frame store. The read port is owned by the sequencer.
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] box_addr;
  pixel_t            rd_data;

  assign wr_addr = {DIM_W'(in_row), DIM_W'(in_col)};

  isc_frame_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pix),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer working state.
  logic [QUO_W-1:0]          sr_r, sr_nxt;
  logic [BOX_CNT_W-1:0]      box_cnt_r, box_cnt_nxt;
  logic [NUM_CH-1:0][ACC_W-1:0] acc_r, acc_nxt;
  pixel_t                    res_pix_r, res_pix_nxt;
  status_t                   res_status_r, res_status_nxt;
  logic                      out_load;

  // The box read count walks the 2x2 block at (2r, 2c): bit 0 picks the
  // lower row, bit 1 the right-hand column.
  assign box_addr = {(DIM_W-1)'(row_r), box_cnt_r[0], (DIM_W-1)'(col_r), box_cnt_r[1]};

  always_comb begin
    state_nxt      = state_r;
    sr_nxt         = sr_r;
    box_cnt_nxt    = box_cnt_r;
    acc_nxt        = acc_r;
    res_pix_nxt    = res_pix_r;
    res_status_nxt = res_status_r;
    div_start      = 1'b0;
    div_dividend   = col_x100;
    rd_en          = 1'b0;
    rd_addr        = box_addr;
    out_load       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_operation == OP_READ)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // The percent is judged before the coordinate.
        if (pct_unsupported) begin
          res_pix_nxt    = '0;
          res_status_nxt = ST_UNSUPPORTED;
          state_nxt      = S_EMIT;
        end else if (!coord_ok) begin
          res_pix_nxt    = '0;
          res_status_nxt = ST_RANGE;
          state_nxt      = S_EMIT;
        end else if (pct_half) begin
          box_cnt_nxt = '0;
          acc_nxt     = '0;
          state_nxt   = S_BOX;
        end else begin
          div_start    = 1'b1;
          div_dividend = row_x100;
          state_nxt    = S_DIVR;
        end
      end
      S_DIVR: begin
        if (div_stat.done) begin
          sr_nxt    = div_quo;
          div_start = 1'b1;
          state_nxt = S_DIVC;
        end
      end
      S_DIVC: begin
        if (div_stat.done) begin
          rd_en     = 1'b1;
          rd_addr   = {sr_r, div_quo};
          state_nxt = S_NNDAT;
        end
      end
      S_NNDAT: begin
        res_pix_nxt    = rd_data;
        res_status_nxt = ST_OK;
        state_nxt      = S_EMIT;
      end
      S_BOX: begin
        // Reads are issued on counts 0 to 3; each read's data is summed
        // in the next cycle, on counts 1 to 4.
        rd_en = (box_cnt_r != BOX_CNT_W'(BOX_READS));
        if (box_cnt_r != '0) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            acc_nxt[ch] = acc_r[ch] + ACC_W'(rd_data[ch]);
          end
        end
        box_cnt_nxt = box_cnt_r + 1'b1;
        if (box_cnt_r == BOX_CNT_W'(BOX_READS)) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        // Truncated mean of four: drop the two low bits of each sum.
        for (int ch = 0; ch < NUM_CH; ch++) begin
          res_pix_nxt[ch] = acc_r[ch][ACC_W-1 -: CHANNEL_BITS];
        end
        res_status_nxt = ST_OK;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r         <= sr_nxt;
    box_cnt_r    <= box_cnt_nxt;
    acc_r        <= acc_nxt;
    res_pix_r    <= res_pix_nxt;
    res_status_r <= res_status_nxt;
  end

  // Output register. A finished result waits here until it is taken.
  logic    out_valid_r;
  pixel_t  out_pix_r;
  status_t out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r    <= res_pix_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r[2];
  assign out_green_out = out_pix_r[1];
  assign out_blue_out  = out_pix_r[0];
  assign out_status    = out_status_r;

  // The divider is only started once its previous division has finished.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A finished division is only ever seen by the two divide states.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIVR || state_r == S_DIVC))
    else $error("division finished outside a divide state");

  // A result with an error status carries black colour channels.
  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_pix_r == '0))
    else $error("error result with non-zero colour");

  // Accepting a read request blocks further requests on the next cycle.
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_operation == OP_READ)) |=> !in_ready)
    else $error("request accepted while a read is in progress");

endmodule
